[design/cnms_pkg.sv]
package cnms_pkg;

  // Number of active channels; channels at or beyond this are absent.
  localparam int Channels = 4;
  // Fixed field count of one beat.
  localparam int NumFields = 4;

  // Increment width after rounding to Q14.16.
  localparam int IncW = 30;

  // Channel kind codes
  localparam logic [1:0] KindWiener  = 2'd1;
  localparam logic [1:0] KindPoisson = 2'd2;

  // Register indexes
  localparam logic [2:0] RegKinds  = 3'd0;
  localparam logic [2:0] RegParamA = 3'd1;
  localparam logic [2:0] RegParamB = 3'd2;
  localparam logic [2:0] RegMix0   = 3'd3;
  localparam logic [2:0] RegMix1   = 3'd4;
  localparam logic [2:0] RegMix2   = 3'd5;
  localparam logic [2:0] RegMix3   = 3'd6;

  // Reset values of the mixing rows: 0.5 on the diagonal
  localparam logic [63:0] MixRst0 = 64'h0000_0000_0000_2000;
  localparam logic [63:0] MixRst1 = 64'h0000_0000_2000_0000;
  localparam logic [63:0] MixRst2 = 64'h0000_2000_0000_0000;
  localparam logic [63:0] MixRst3 = 64'h2000_0000_0000_0000;

  typedef logic [NumFields-1:0][15:0] word_vec_t;

  typedef struct packed {
    logic signed [15:0] gauss_3;
    logic signed [15:0] gauss_2;
    logic signed [15:0] gauss_1;
    logic signed [15:0] gauss_0;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;
    logic [3:0]         event_flags;
  } out_item_t;

  // What one lane hands to the accumulate stage
  typedef struct packed {
    logic                   event_hit;
    logic signed [IncW-1:0] inc;
  } lane_res_t;

  typedef lane_res_t [NumFields-1:0] lane_res_vec_t;

endpackage

[design/cnms_lane.sv]
module cnms_lane (
  input  logic                     clk,
  input  logic                     in_en,
  input  logic                     mid_en,
  input  logic                     late_en,
  input  cnms_pkg::word_vec_t      gauss,
  input  cnms_pkg::word_vec_t      coef,
  input  logic [1:0]               kind,
  input  logic signed [15:0]       pa,
  input  logic signed [15:0]       pb,
  output cnms_pkg::lane_res_t      res
);

  logic signed [31:0] prod_r [cnms_pkg::NumFields];
  logic signed [33:0] omega_r;
  logic signed [33:0] omega_nxt;
  logic signed [49:0] mul_r;
  logic               hit_r;
  logic signed [33:0] thresh;
  logic signed [51:0] t_sum;
  logic signed [51:0] t_rnd;

  // Multiply each source by its weight; sources beyond the channel count drop out
  always_ff @(posedge clk) begin
    if (in_en) begin
      for (int n = 0; n < cnms_pkg::NumFields; n++) begin
        if (n < cnms_pkg::Channels) begin
          prod_r[n] <= 32'($signed(gauss[n])) * 32'($signed(coef[n]));
        end else begin
          prod_r[n] <= '0;
        end
      end
    end
  end

  // Sum the products into the indicator
  always_comb begin
    omega_nxt = '0;
    for (int n = 0; n < cnms_pkg::NumFields; n++) begin
      omega_nxt = omega_nxt + 34'(prod_r[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (mid_en) begin
      omega_r <= omega_nxt;
    end
  end

  // Scale by diffusion and compare against the threshold at 26 fraction bits
  assign thresh = 34'(pa) <<< 14;

  always_ff @(posedge clk) begin
    if (late_en) begin
      mul_r <= 50'(pb) * 50'(omega_r);
      hit_r <= omega_r > thresh;
    end
  end

  // Add drift, round half up to 16 fraction bits
  assign t_sum = (52'(pa) <<< 26) + 52'(mul_r);
  assign t_rnd = t_sum + (52'sd1 <<< 21);

  always_comb begin
    res = '0;
    case (kind)
      cnms_pkg::KindWiener: begin
        res.inc = t_rnd[51:22];
      end
      cnms_pkg::KindPoisson: begin
        if (hit_r) begin
          res.event_hit = 1'b1;
          res.inc       = cnms_pkg::IncW'(pb) <<< 4;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

[design/cnms_accum.sv]
module cnms_accum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  logic                      out_ready,
  input  cnms_pkg::lane_res_vec_t   res,
  output logic                      out_valid,
  output cnms_pkg::out_item_t       out_data
);

  logic signed [31:0] acc_r   [cnms_pkg::NumFields];
  logic signed [31:0] acc_nxt [cnms_pkg::NumFields];
  logic [3:0]         flags_r;
  logic [3:0]         flags_nxt;
  logic               valid_r;
  logic signed [32:0] sum;

  // Saturating add of each lane's increment
  always_comb begin
    sum = '0;
    for (int c = 0; c < cnms_pkg::NumFields; c++) begin
      sum        = 33'(acc_r[c]) + 33'(res[c].inc);
      flags_nxt[c] = res[c].event_hit;
      if (sum[32] != sum[31]) begin
        acc_nxt[c] = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        acc_nxt[c] = sum[31:0];
      end
    end
  end

  // Hold accumulators and the result beat; advance on fire
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < cnms_pkg::NumFields; c++) begin
        acc_r[c] <= '0;
      end
      flags_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (fire) begin
        for (int c = 0; c < cnms_pkg::NumFields; c++) begin
          acc_r[c] <= acc_nxt[c];
        end
        flags_r <= flags_nxt;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = valid_r;
  assign out_data.value_0     = acc_r[0];
  assign out_data.value_1     = acc_r[1];
  assign out_data.value_2     = acc_r[2];
  assign out_data.value_3     = acc_r[3];
  assign out_data.event_flags = flags_r;

endmodule

[design/correlated_noise_mix_step_unit.sv]
// Channel | Ports                                   | Beat
// in      | in_valid, in_ready, in_data             | four Q4.12 samples
// out     | out_valid, out_ready, out_data          | four Q16.16 values, event flags
// cfg     | psel, penable, pwrite, paddr, pwdata,   | registers at 8*index
//         | prdata, pready                          |
// A beat passes registered stages from acceptance to the result register: weight
// products, indicator sum, diffusion multiply, then the saturating accumulate.
// One beat is in flight at a time; a new beat waits until the last is accumulated.
// A stalled result holds the last stage; the next beat is taken once it moves out.
// Synchronous active-low reset clears accumulators and flags, and resets registers.
module correlated_noise_mix_step_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cnms_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cnms_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  logic [7:0]  kinds_r;
  logic [63:0] pa_r;
  logic [63:0] pb_r;
  logic [63:0] mix_r [cnms_pkg::NumFields];
  logic [2:0]  reg_idx;
  logic        wr_en;

  logic        v1_r;
  logic        v2_r;
  logic        v3_r;
  logic        accept;
  logic        fire;

  cnms_pkg::word_vec_t     gauss;
  cnms_pkg::word_vec_t     pa_vec;
  cnms_pkg::word_vec_t     pb_vec;
  cnms_pkg::lane_res_vec_t res;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kinds_r  <= '0;
      pa_r     <= '0;
      pb_r     <= '0;
      mix_r[0] <= cnms_pkg::MixRst0;
      mix_r[1] <= cnms_pkg::MixRst1;
      mix_r[2] <= cnms_pkg::MixRst2;
      mix_r[3] <= cnms_pkg::MixRst3;
    end else if (wr_en) begin
      case (reg_idx)
        cnms_pkg::RegKinds:  kinds_r  <= pwdata[7:0];
        cnms_pkg::RegParamA: pa_r     <= pwdata;
        cnms_pkg::RegParamB: pb_r     <= pwdata;
        cnms_pkg::RegMix0:   mix_r[0] <= pwdata;
        cnms_pkg::RegMix1:   mix_r[1] <= pwdata;
        cnms_pkg::RegMix2:   mix_r[2] <= pwdata;
        cnms_pkg::RegMix3:   mix_r[3] <= pwdata;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cnms_pkg::RegKinds:  prdata = {56'd0, kinds_r};
      cnms_pkg::RegParamA: prdata = pa_r;
      cnms_pkg::RegParamB: prdata = pb_r;
      cnms_pkg::RegMix0:   prdata = mix_r[0];
      cnms_pkg::RegMix1:   prdata = mix_r[1];
      cnms_pkg::RegMix2:   prdata = mix_r[2];
      cnms_pkg::RegMix3:   prdata = mix_r[3];
      default:             prdata = '0;
    endcase
  end

  // Stage tracking: one beat in flight
  assign in_ready = !(v1_r || v2_r || v3_r);
  assign accept   = in_valid && in_ready;
  assign fire     = v3_r && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r || (v3_r && !fire);
    end
  end

  assign gauss  = {in_data.gauss_3, in_data.gauss_2, in_data.gauss_1, in_data.gauss_0};
  assign pa_vec = pa_r;
  assign pb_vec = pb_r;

  // Mixing lanes, one per channel
  for (genvar c = 0; c < cnms_pkg::NumFields; c++) begin : g_lane
    if (c < cnms_pkg::Channels) begin : g_on
      cnms_lane u_lane (
        .clk     (clk),
        .in_en   (accept),
        .mid_en  (v1_r),
        .late_en (v2_r),
        .gauss   (gauss),
        .coef    (mix_r[c]),
        .kind    (kinds_r[2*c +: 2]),
        .pa      ($signed(pa_vec[c])),
        .pb      ($signed(pb_vec[c])),
        .res     (res[c])
      );
    end else begin : g_off
      assign res[c] = '0;
    end
  end

  // Accumulate and present the result beat
  cnms_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .out_ready (out_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[bench/cnms_step_checker.sv]
`timescale 1ns / 1ps

// Watches the sample, result and register ports, keeps its own copy of the
// registers and accumulators, predicts each result beat and compares it.
module cnms_step_checker
  import cnms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output int          mismatch_count,
  output int          steps_pending
);

  // Register and accumulator copies
  logic [7:0]         kinds_q;
  logic [63:0]        param_a_q;
  logic [63:0]        param_b_q;
  logic [63:0]        mix_q [4];
  logic signed [31:0] level_q [4];

  out_item_t          step_q [$];
  int                 errs;

  function automatic logic signed [15:0] lane_word(logic [63:0] r, int k);
    return r[16*k +: 16];
  endfunction

  // Add with clamping to the signed 32-bit range
  function automatic logic signed [31:0] add_clamped(logic signed [31:0] acc,
                                                     longint inc);
    longint s;
    s = longint'(acc) + inc;
    if (s > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (s < -64'sd2147483648) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  // Mix the samples, advance every channel and build the expected beat
  function automatic out_item_t mix_and_accumulate(in_item_t beat);
    out_item_t          res;
    logic signed [15:0] g [4];
    logic [1:0]         kind;
    longint             omega;
    longint             pa;
    longint             pb;
    longint             incr;
    g[0] = beat.gauss_0;
    g[1] = beat.gauss_1;
    g[2] = beat.gauss_2;
    g[3] = beat.gauss_3;
    res = '0;
    for (int c = 0; c < 4 && c < Channels; c++) begin
      kind  = kinds_q[2*c +: 2];
      pa    = lane_word(param_a_q, c);
      pb    = lane_word(param_b_q, c);
      omega = 0;
      for (int n = 0; n < 4 && n < Channels; n++) begin
        omega += longint'(lane_word(mix_q[c], n)) * longint'(g[n]);
      end
      if (kind == KindWiener) begin
        // 38 fraction bits, round half up to 16
        incr = ((pa <<< 26) + pb * omega + (64'sd1 <<< 21)) >>> 22;
        level_q[c] = add_clamped(level_q[c], incr);
      end else if (kind == KindPoisson) begin
        if (omega > (pa <<< 14)) begin
          level_q[c] = add_clamped(level_q[c], pb <<< 4);
          res.event_flags[c] = 1'b1;
        end
      end
    end
    res.value_0 = level_q[0];
    res.value_1 = level_q[1];
    res.value_2 = level_q[2];
    res.value_3 = level_q[3];
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      kinds_q   = '0;
      param_a_q = '0;
      param_b_q = '0;
      mix_q[0]  = MixRst0;
      mix_q[1]  = MixRst1;
      mix_q[2]  = MixRst2;
      mix_q[3]  = MixRst3;
      for (int c = 0; c < 4; c++) level_q[c] = '0;
      step_q.delete();
    end else begin
      // Mirror register writes; unused indexes are dropped
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          RegKinds:  kinds_q   = pwdata[7:0];
          RegParamA: param_a_q = pwdata;
          RegParamB: param_b_q = pwdata;
          RegMix0:   mix_q[0]  = pwdata;
          RegMix1:   mix_q[1]  = pwdata;
          RegMix2:   mix_q[2]  = pwdata;
          RegMix3:   mix_q[3]  = pwdata;
          default: ;
        endcase
      end
      // Compare a result beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (step_q.size() == 0) begin
          $error("result beat with no step pending");
          errs++;
        end else begin
          want = step_q.pop_front();
          check_field("value_0", want.value_0, out_data.value_0);
          check_field("value_1", want.value_1, out_data.value_1);
          check_field("value_2", want.value_2, out_data.value_2);
          check_field("value_3", want.value_3, out_data.value_3);
          check_field("event_flags", {28'd0, want.event_flags},
                      {28'd0, out_data.event_flags});
        end
      end
      // Predict the beat for each accepted sample set
      if (in_valid && in_ready) step_q.push_back(mix_and_accumulate(in_data));
    end
    mismatch_count <= errs;
    steps_pending  <= step_q.size();
  end

endmodule

[bench/tb_correlated_noise_mix_step_unit.sv]
`timescale 1ns / 1ps

module tb_correlated_noise_mix_step_unit;
  import cnms_pkg::*;

  localparam logic [2:0] RegUnused   = 3'd7;
  localparam int         CycleLimit  = 200000;
  localparam int         DrainCycles = 10;
  localparam int         HoldCycles  = 80;
  localparam int         NumPhases   = 9;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int          mismatch_count;
  int          steps_pending;
  int          sample_cnt = 0;
  int          cycle_cnt = 0;
  int          sender_idle_pct = 33;
  int          recv_idle_pct = 86;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  correlated_noise_mix_step_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  cnms_step_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .steps_pending  (steps_pending)
  );

  // Result side: one long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("** correlated_noise_mix_step_unit: FAILED **");
      $finish;
    end
  end

  function automatic in_item_t mk_sample(logic [15:0] a, logic [15:0] b,
                                         logic [15:0] c, logic [15:0] d);
    in_item_t s;
    s.gauss_0 = a;
    s.gauss_1 = b;
    s.gauss_2 = c;
    s.gauss_3 = d;
    return s;
  endfunction

  // One Q4.12 sample: full range, near zero, corner codes, large +/- only
  function automatic logic [15:0] rand_lane(int style);
    case (style)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 16384)) - 16'd8192;
      2: begin
        case ($urandom_range(0, 4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      3: return 16'($urandom_range(28000, 32767));
      default: return 16'(65536 - $urandom_range(28000, 32768));
    endcase
  endfunction

  // Four signed lanes: full range when span is zero, else within +/-span
  function automatic logic [63:0] rand_lanes(int span);
    logic [63:0] w;
    if (span == 0) return {$urandom, $urandom};
    for (int k = 0; k < 4; k++) w[16*k +: 16] = 16'($urandom_range(0, 2*span)) - 16'(span);
    return w;
  endfunction

  function automatic int phase_len(int p);
    case (p)
      0: return 90;
      1: return 40;
      2: return 15;
      3: return 15;
      4: return 160;
      default: return 25;
    endcase
  endfunction

  function automatic in_item_t phase_sample(int p);
    int style;
    if (p == 0) style = 3;
    else if (p == 4) style = 4;
    else style = $urandom_range(0, 2);
    return mk_sample(rand_lane(style), rand_lane(style), rand_lane(style),
                     rand_lane(style));
  endfunction

  // Setup, then access until pready; bus idle after
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_all(input logic [7:0] kinds, input logic [63:0] pa,
                         input logic [63:0] pb, input logic [63:0] r0,
                         input logic [63:0] r1, input logic [63:0] r2,
                         input logic [63:0] r3);
    cfg_write(RegKinds, {56'd0, kinds});
    cfg_write(RegParamA, pa);
    cfg_write(RegParamB, pb);
    cfg_write(RegMix0, r0);
    cfg_write(RegMix1, r1);
    cfg_write(RegMix2, r2);
    cfg_write(RegMix3, r3);
  endtask

  task automatic apply_phase_config(input int p);
    logic [7:0] kinds;
    case (p)
      // all Wiener, driven to the top rail
      0: cfg_all(8'h55, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}},
                 {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
      // all Poisson, lowest threshold: events while clamped
      1: cfg_all(8'hAA, {4{16'h8000}}, {4{16'h7FFF}}, rand_lanes(0),
                 rand_lanes(0), rand_lanes(0), rand_lanes(0));
      // kind three everywhere: hold
      2: cfg_all(8'hFF, rand_lanes(0), rand_lanes(0), rand_lanes(0),
                 rand_lanes(0), rand_lanes(0), rand_lanes(0));
      3: cfg_all(8'h00, '0, '0, '0, '0, '0, '0);
      // all Wiener, most negative diffusion: down to the bottom rail
      4: cfg_all(8'h55, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
                 {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
      default: begin
        kinds = 8'($urandom);
        if (p[0]) begin
          cfg_all(kinds, rand_lanes(0), rand_lanes(0), rand_lanes(0),
                  rand_lanes(0), rand_lanes(0), rand_lanes(0));
        end else begin
          cfg_all(kinds, rand_lanes(4096), rand_lanes(4096), rand_lanes(8192),
                  rand_lanes(8192), rand_lanes(8192), rand_lanes(8192));
        end
      end
    endcase
  endtask

  // Offer one beat, with random idle cycles ahead of it
  task automatic send_sample(input in_item_t beat);
    if (sample_cnt == 140) begin
      sender_idle_pct <= 86;
      recv_idle_pct   <= 33;
    end else if (sample_cnt == 280) begin
      sender_idle_pct <= 0;
      recv_idle_pct   <= 0;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    sample_cnt++;
  endtask

  task automatic drain_results();
    do @(posedge clk); while (steps_pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: kind zero on every channel, so no channel moves
    send_sample(mk_sample(16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF));
    send_sample(mk_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(mk_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
    in_valid <= 1'b0;
    drain_results();

    // Wiener up, Wiener down, Poisson at a threshold of one LSB, kind three
    cfg_all(8'hE5, {16'h0000, 16'h0001, 16'h8000, 16'h7FFF},
            {16'h1234, 16'h7FFF, 16'h8000, 16'h7FFF}, {4{16'h7FFF}},
            {4{16'h8000}}, {4{16'h4000}}, 64'hFFFF_0001_8000_7FFF);
    cfg_write(RegUnused, '1);

    // Indicator below, equal to, then just above the threshold
    send_sample(mk_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(mk_sample(16'h0001, 16'h0000, 16'h0000, 16'h0000));
    send_sample(mk_sample(16'h0001, 16'h0001, 16'h0000, 16'h0000));
    // Field extremes and single sources
    send_sample(mk_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_sample(mk_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_sample(mk_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
    send_sample(mk_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(mk_sample(16'h0001, 16'h0002, 16'h0004, 16'h0008));
    send_sample(mk_sample(16'h8000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(mk_sample(16'h0000, 16'h8000, 16'h0000, 16'h0000));
    send_sample(mk_sample(16'h0000, 16'h0000, 16'h8000, 16'h0000));
    send_sample(mk_sample(16'h0000, 16'h0000, 16'h0000, 16'h8000));
    send_sample(mk_sample(16'h7FFF, 16'h0000, 16'h0000, 16'h0000));
    send_sample(mk_sample(16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC));
    in_valid <= 1'b0;
    drain_results();

    // Random phases, each under its own settings
    for (int p = 0; p < NumPhases; p++) begin
      apply_phase_config(p);
      if (p == 5) hold_go <= 1'b1;
      for (int i = 0; i < phase_len(p); i++) send_sample(phase_sample(p));
      in_valid <= 1'b0;
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("** correlated_noise_mix_step_unit: PASSED **");
    end else begin
      $display("** correlated_noise_mix_step_unit: FAILED **");
    end
    $finish;
  end

endmodule

[correlated_noise_mix_step_unit.f]
design/cnms_pkg.sv
design/cnms_lane.sv
design/cnms_accum.sv
design/correlated_noise_mix_step_unit.sv
bench/cnms_step_checker.sv
bench/tb_correlated_noise_mix_step_unit.sv
